FILE: rtl/core/fsd_pkg.sv
`timescale 1ns / 1ps
package fsd_pkg;

    // width of the exact fixed-point working registers
    localparam int DP_W          = 192;
    localparam int DEF_MAX_SCALE = 28;
    localparam int LO_POW        = 28;
    localparam int MAX_DOWN      = 40;
    localparam int LO_W          = 128;
    localparam int COEF_W        = 96;

    localparam logic [DP_W-1:0] C_TEN7   = DP_W'(64'd10000000);
    localparam logic [DP_W-1:0] C_SIX9   = DP_W'(64'd999999);
    // 7922816 * 10^22
    localparam logic [DP_W-1:0] C_HI_LIM = DP_W'(128'd79228160000000000000000000000);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_CHKLO,
        S_DOWN,
        S_UP,
        S_DIV,
        S_RND,
        S_MUL,
        S_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LSTEP,
        OP_DOWN,
        OP_UP,
        OP_DIVI,
        OP_DIVS,
        OP_RND,
        OP_MULS
    } t_op;

    typedef enum logic [1:0] {
        RES_OK,
        RES_ZERO,
        RES_FAIL
    } t_res;

    typedef struct packed {
        t_op  op;
        logic out_load;
        t_res kind;
    } t_cmd;

    typedef struct packed {
        logic is_nan;
        logic is_zero;
        logic neg_exp;
        logic hi_fail;
        logic lo_fail;
        logic down_go;
        logic up_go;
        logic cnt_zero;
        logic k_zero;
    } t_stat;

    function automatic logic [DP_W-1:0] mul10(input logic [DP_W-1:0] x);
        mul10 = (x << 3) + (x << 1);
    endfunction

endpackage

FILE: rtl/core/fsd_datapath.sv
`timescale 1ns / 1ps
module fsd_datapath import fsd_pkg::*; #(
    parameter int MAX_SCALE = DEF_MAX_SCALE
) (
    input  logic                 i_clk,
    input  logic [31:0]          i_float_bits,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic [63:0]          o_coeff_low,
    output logic [31:0]          o_coeff_high,
    output logic [4:0]           o_decimal_scale,
    output logic                 o_negative,
    output logic                 o_failed
);

    // value = r_n / r_p ; r_t7 = 1e7 * r_p ; r_t6 = 999999 * r_p
    logic [DP_W-1:0]   r_n, r_p, r_t7, r_t6, r_rem, r_q;
    logic [LO_W-1:0]   r_l;
    logic [7:0]        r_a;
    logic              r_nan, r_zero, r_neg;
    logic [24:0]       r_r;
    logic [5:0]        r_k;
    logic [4:0]        r_s, r_cnt;
    logic [COEF_W-1:0] r_coef;
    logic [63:0]       r_o_low;
    logic [31:0]       r_o_high;
    logic [4:0]        r_o_scale;
    logic              r_o_neg, r_o_fail;

    logic [7:0]  ef;
    logic [23:0] mant;
    logic        e_pos;
    logic [7:0]  sh_up, sh_dn;
    logic        div_ge, rnd_up;

    always_comb begin
        ef     = i_float_bits[30:23];
        mant   = (ef == 8'd0) ? {1'b0, i_float_bits[22:0]} : {1'b1, i_float_bits[22:0]};
        e_pos  = (ef >= 8'd150);
        sh_up  = ef - 8'd150;
        sh_dn  = (ef == 8'd0) ? 8'd149 : 8'd150 - ef;
        div_ge = (r_rem >= r_q);
        rnd_up = ({r_rem[DP_W-2:0], 1'b0} >= r_p);
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_nan  <= (ef == 8'hFF);
                r_zero <= (mant == 24'd0);
                r_neg  <= i_float_bits[31];
                r_l    <= LO_W'(mant);
                r_k    <= '0;
                r_s    <= '0;
                r_cnt  <= 5'(LO_POW);
                if (e_pos) begin
                    r_n  <= DP_W'(mant) << sh_up;
                    r_a  <= '0;
                    r_p  <= DP_W'(1);
                    r_t7 <= C_TEN7;
                    r_t6 <= C_SIX9;
                end else begin
                    r_n  <= DP_W'(mant);
                    r_a  <= sh_dn;
                    r_p  <= DP_W'(1) << sh_dn;
                    r_t7 <= C_TEN7 << sh_dn;
                    r_t6 <= C_SIX9 << sh_dn;
                end
            end
            OP_LSTEP: begin
                r_l   <= (r_l << 3) + (r_l << 1);
                r_cnt <= r_cnt - 5'd1;
            end
            OP_DOWN: begin
                r_p  <= mul10(r_p);
                r_t7 <= mul10(r_t7);
                r_t6 <= mul10(r_t6);
                r_k  <= r_k + 6'd1;
            end
            OP_UP: begin
                r_n <= mul10(r_n);
                r_s <= r_s + 5'd1;
            end
            OP_DIVI: begin
                r_rem <= r_n;
                r_q   <= r_p << 24;
                r_cnt <= 5'd24;
                r_r   <= '0;
            end
            OP_DIVS: begin
                if (div_ge) begin
                    r_rem <= r_rem - r_q;
                end
                r_r   <= {r_r[23:0], div_ge};
                r_q   <= r_q >> 1;
                r_cnt <= r_cnt - 5'd1;
            end
            OP_RND: begin
                r_coef <= COEF_W'(r_r) + COEF_W'(rnd_up);
            end
            OP_MULS: begin
                r_coef <= (r_coef << 3) + (r_coef << 1);
                r_k    <= r_k - 6'd1;
            end
            default: begin
            end
        endcase

        if (i_cmd.out_load) begin
            unique case (i_cmd.kind)
                RES_OK: begin
                    r_o_low   <= r_coef[63:0];
                    r_o_high  <= r_coef[95:64];
                    r_o_scale <= r_s;
                    r_o_neg   <= r_neg;
                    r_o_fail  <= 1'b0;
                end
                RES_ZERO: begin
                    r_o_low   <= '0;
                    r_o_high  <= '0;
                    r_o_scale <= '0;
                    r_o_neg   <= 1'b0;
                    r_o_fail  <= 1'b0;
                end
                default: begin
                    r_o_low   <= '0;
                    r_o_high  <= '0;
                    r_o_scale <= '0;
                    r_o_neg   <= 1'b0;
                    r_o_fail  <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.is_nan   = r_nan;
        o_stat.is_zero  = r_zero;
        o_stat.neg_exp  = (r_a != 8'd0);
        o_stat.hi_fail  = (r_n > C_HI_LIM);
        o_stat.lo_fail  = (DP_W'(r_l) < (DP_W'(1) << r_a));
        o_stat.down_go  = (r_n >= r_t7) && (r_k < 6'(MAX_DOWN));
        o_stat.up_go    = (r_n < r_t6) && (r_s < 5'(MAX_SCALE));
        o_stat.cnt_zero = (r_cnt == 5'd0);
        o_stat.k_zero   = (r_k == 6'd0);
    end

    assign o_coeff_low     = r_o_low;
    assign o_coeff_high    = r_o_high;
    assign o_decimal_scale = r_o_scale;
    assign o_negative      = r_o_neg;
    assign o_failed        = r_o_fail;

endmodule

FILE: rtl/core/fsd_ctrl.sv
`timescale 1ns / 1ps
module fsd_ctrl import fsd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output logic  o_out_valid,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    t_res   r_kind, n_kind;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= RES_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_kind         = r_kind;
        n_out_valid    = r_out_valid && i_out_stall;
        o_cmd.op       = OP_NONE;
        o_cmd.out_load = 1'b0;
        o_cmd.kind     = r_kind;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CLASS;
                end
            end
            S_CLASS: begin
                priority if (i_stat.is_nan) begin
                    n_kind  = RES_FAIL;
                    n_state = S_FIN;
                end else if (i_stat.is_zero) begin
                    n_kind  = RES_ZERO;
                    n_state = S_FIN;
                end else if (i_stat.hi_fail) begin
                    n_kind  = RES_FAIL;
                    n_state = S_FIN;
                end else if (i_stat.neg_exp) begin
                    n_state = S_CHKLO;
                end else begin
                    n_state = S_DOWN;
                end
            end
            S_CHKLO: begin
                // m * 10^28 against 2^-e
                if (!i_stat.cnt_zero) begin
                    o_cmd.op = OP_LSTEP;
                end else if (i_stat.lo_fail) begin
                    n_kind  = RES_FAIL;
                    n_state = S_FIN;
                end else begin
                    n_state = S_DOWN;
                end
            end
            S_DOWN: begin
                if (i_stat.down_go) begin
                    o_cmd.op = OP_DOWN;
                end else begin
                    n_state = S_UP;
                end
            end
            S_UP: begin
                if (i_stat.up_go) begin
                    o_cmd.op = OP_UP;
                end else begin
                    o_cmd.op = OP_DIVI;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIVS;
                if (i_stat.cnt_zero) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                o_cmd.op = OP_RND;
                n_state  = S_MUL;
            end
            S_MUL: begin
                if (!i_stat.k_zero) begin
                    o_cmd.op = OP_MULS;
                end else begin
                    n_kind  = RES_OK;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/float_to_scaled_decimal.sv
`timescale 1ns / 1ps
// Converts one IEEE single (i_float_bits) into a 96-bit decimal coefficient with a
// power-of-ten scale, sign and error flag, using exact fixed point throughout. One beat
// is taken at a time. NaN, infinity, zero and too large values end early with a zero or
// failed result, as does a nonzero magnitude found below 1e-28. Here k is the number of
// divide-by-ten steps (at most 22) and s is the output scale. The steps run one per cycle
// on the shared datapath: the 28-step low-range check and its compare cycle when the
// exponent is negative, the 25-step restoring division, and the k multiply-by-ten steps
// that rebuild the coefficient. The finished beat sits in an output register, so the
// block returns to accept a new beat while that result waits. The next result is held
// back while the previous one is still stalled.
module float_to_scaled_decimal import fsd_pkg::*; #(
    parameter int MAX_SCALE = DEF_MAX_SCALE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_float_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_coeff_low,
    output logic [31:0] o_coeff_high,
    output logic [4:0]  o_decimal_scale,
    output logic        o_negative,
    output logic        o_failed
);

    t_cmd  cmd;
    t_stat stat;

    fsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_stall (i_stall),
        .i_stat      (stat),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    fsd_datapath #(
        .MAX_SCALE (MAX_SCALE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_float_bits    (i_float_bits),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_coeff_low     (o_coeff_low),
        .o_coeff_high    (o_coeff_high),
        .o_decimal_scale (o_decimal_scale),
        .o_negative      (o_negative),
        .o_failed        (o_failed)
    );

endmodule
